### sv/cdc_pkg.sv
// ----------------------------------------------------------------------------
// cdc_pkg
// Shared types, constants and calendar functions for the date counter.
// ----------------------------------------------------------------------------
package cdc_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned WdayW  = 3;
  localparam int unsigned RemYW  = 9;
  localparam int unsigned WsumW  = 14;

  // Action codes of an input transaction.
  localparam logic ACT_ADVANCE = 1'b0;
  localparam logic ACT_LOAD    = 1'b1;

  localparam logic [YearW-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MonthW-1:0] MONTH_JAN = 4'd1;
  localparam logic [MonthW-1:0] MONTH_FEB = 4'd2;
  localparam logic [MonthW-1:0] MONTH_DEC = 4'd12;
  localparam logic [WdayW-1:0]  WDAY_FRI  = 3'd5;
  localparam logic [WdayW-1:0]  WDAY_SAT  = 3'd6;
  localparam logic [WdayW-1:0]  WDAY_MON  = 3'd1;

  // x / 25 == (x * 5243) >> 17 for every x below 4096.
  localparam logic [12:0] DIV25_MULT  = 13'd5243;
  localparam int unsigned DIV25_SHIFT = 17;

  localparam logic [RemYW-1:0] DAYS_LEAP_REM   = 9'd365;
  localparam logic [RemYW-1:0] DAYS_COMMON_REM = 9'd364;

  // Stored date together with the counters that make leap years and
  // weekdays cheap to follow from one day to the next.
  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic [1:0]        y4;    // year mod 4
    logic [6:0]        y100;  // year mod 100
    logic [1:0]        c4;    // (year / 100) mod 4
    logic [WdayW-1:0]  wd;
    logic [RemYW-1:0]  rem_y;
  } date_state_t;

  localparam date_state_t DATE_RESET = '{
    day:   5'd1,
    month: 4'd1,
    year:  14'd1,
    y4:    2'd1,
    y100:  7'd1,
    c4:    2'd0,
    wd:    WDAY_MON,
    rem_y: DAYS_COMMON_REM
  };

  // Everything a load transaction needs, worked out ahead of the state update.
  typedef struct packed {
    logic              ok;
    logic [6:0]        y100;
    logic [1:0]        c4;
    logic [WsumW-1:0]  wsum;
    logic [RemYW-1:0]  rem_y;
  } load_info_t;

  function automatic logic is_leap(logic [1:0] y4, logic [6:0] y100, logic [1:0] c4);
    return (y4 == 2'd0) && ((y100 != 7'd0) || (c4 == 2'd0));
  endfunction

  function automatic logic [DayW-1:0] month_len(logic [MonthW-1:0] month, logic leap);
    logic [DayW-1:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // 31 * m / 12 with March as m = 1 and January, February as 11 and 12.
  function automatic logic [4:0] month_term(logic [MonthW-1:0] month);
    logic [4:0] t;
    unique case (month)
      4'd1:    t = 5'd28;
      4'd2:    t = 5'd31;
      4'd3:    t = 5'd2;
      4'd4:    t = 5'd5;
      4'd5:    t = 5'd7;
      4'd6:    t = 5'd10;
      4'd7:    t = 5'd12;
      4'd8:    t = 5'd15;
      4'd9:    t = 5'd18;
      4'd10:   t = 5'd20;
      4'd11:   t = 5'd23;
      4'd12:   t = 5'd25;
      default: t = 5'd0;
    endcase
    return t;
  endfunction

  // Days in the months after this one, with a common February.
  function automatic logic [RemYW-1:0] days_after(logic [MonthW-1:0] month);
    logic [RemYW-1:0] d;
    unique case (month)
      4'd1:    d = 9'd334;
      4'd2:    d = 9'd306;
      4'd3:    d = 9'd275;
      4'd4:    d = 9'd245;
      4'd5:    d = 9'd214;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd153;
      4'd8:    d = 9'd122;
      4'd9:    d = 9'd92;
      4'd10:   d = 9'd61;
      4'd11:   d = 9'd31;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Since 8 is 1 mod 7, summing octal digits keeps the residue.
  function automatic logic [WdayW-1:0] mod7(logic [WsumW-1:0] v);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[11:9]) + 5'(v[13:12]);
    s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

endpackage

### sv/cdc_load_prep.sv
// ----------------------------------------------------------------------------
// cdc_load_prep
// Checks a date to be loaded and works out its weekday sum, leap counters and
// days left in the year.
// ----------------------------------------------------------------------------
module cdc_load_prep import cdc_pkg::*; (
  input  logic [DayW-1:0]   day_i,
  input  logic [MonthW-1:0] month_i,
  input  logic [YearW-1:0]  year_i,
  input  logic [7:0]        q100_i,   // year / 100
  output load_info_t        info_o
);

  logic [YearW-1:0] r100_full;
  logic [6:0]       r100;
  logic [1:0]       y4;
  logic             leap;
  logic [DayW-1:0]  mlen;
  logic             early;
  logic [YearW-1:0] yv;
  logic [11:0]      yq4;
  logic [7:0]       yq100;
  logic [5:0]       yq400;

  assign r100_full = year_i - 14'(14'(q100_i) * 14'd100);
  assign r100      = r100_full[6:0];
  assign y4        = year_i[1:0];
  assign leap      = is_leap(y4, r100, q100_i[1:0]);
  assign mlen      = month_len(month_i, leap);

  // January and February count as the last months of the year before.
  assign early = (month_i == MONTH_JAN) || (month_i == MONTH_FEB);
  assign yv    = year_i - 14'(early);
  assign yq4   = year_i[13:2] - 12'(early && (y4 == 2'd0));
  assign yq100 = q100_i - 8'(early && (r100 == 7'd0));
  assign yq400 = yq100[7:2];

  assign info_o.ok = (month_i != 4'd0) && (month_i <= MONTH_DEC) &&
                     (year_i != 14'd0) && (year_i <= YEAR_MAX) &&
                     (day_i != 5'd0) && (day_i <= mlen);
  assign info_o.y100 = r100;
  assign info_o.c4   = q100_i[1:0];
  assign info_o.wsum = 14'(day_i) + yv + 14'(yq4) - 14'(yq100) + 14'(yq400) +
                       14'(month_term(month_i));
  assign info_o.rem_y = days_after(month_i) + 9'(leap && (month_i == MONTH_JAN)) +
                        9'(mlen - day_i);

endmodule

### sv/cdc_date_step.sv
// ----------------------------------------------------------------------------
// cdc_date_step
// Advances the stored date by one day, with its leap counters, weekday and
// days left in the year.
// ----------------------------------------------------------------------------
module cdc_date_step import cdc_pkg::*; (
  input  date_state_t cur_i,
  output date_state_t nxt_o
);

  logic            leap_cur;
  logic [DayW-1:0] mlen;
  logic [WdayW-1:0] wd_inc;

  assign leap_cur = is_leap(cur_i.y4, cur_i.y100, cur_i.c4);
  assign mlen     = month_len(cur_i.month, leap_cur);
  assign wd_inc   = (cur_i.wd == WDAY_SAT) ? 3'd0 : cur_i.wd + 3'd1;

  always_comb begin
    date_state_t n;
    n       = cur_i;
    n.wd    = wd_inc;
    n.rem_y = cur_i.rem_y - 9'd1;
    priority if (cur_i.day < mlen) begin
      n.day = cur_i.day + 5'd1;
    end else if (cur_i.month < MONTH_DEC) begin
      n.day   = 5'd1;
      n.month = cur_i.month + 4'd1;
    end else begin
      n.day   = 5'd1;
      n.month = MONTH_JAN;
      if (cur_i.year >= YEAR_MAX) begin
        // The calendar wraps to year 1, whose first day is a Monday.
        n.year = DATE_RESET.year;
        n.y4   = DATE_RESET.y4;
        n.y100 = DATE_RESET.y100;
        n.c4   = DATE_RESET.c4;
        n.wd   = DATE_RESET.wd;
      end else begin
        n.year = cur_i.year + 14'd1;
        n.y4   = cur_i.y4 + 2'd1;
        if (cur_i.y100 == 7'd99) begin
          n.y100 = 7'd0;
          n.c4   = cur_i.c4 + 2'd1;
        end else begin
          n.y100 = cur_i.y100 + 7'd1;
        end
      end
      n.rem_y = is_leap(n.y4, n.y100, n.c4) ? DAYS_LEAP_REM : DAYS_COMMON_REM;
    end
    nxt_o = n;
  end

endmodule

### sv/calendar_date_counter.sv
// ----------------------------------------------------------------------------
// calendar_date_counter
// Gregorian date counter with weekday, weekend flag and days remaining.
//
// Each transaction either advances the date by one day or loads a new date,
// and each yields exactly one result transaction showing the date after it.
// The block accepts one transaction per clock cycle while in_stall is low and
// presents its result on the outputs once the transaction has passed the
// input register, two preparation stages and the state register. A load uses
// the preparation stages (one 12 x 13 bit multiplier for year / 100, then the
// validity check and weekday sum); the date itself is updated at the state
// register, so advances and loads may follow one another in consecutive
// cycles. A rejected load leaves the date unchanged and sets load_error.
// After reset the date is 1 January of year 1.
// ----------------------------------------------------------------------------
module calendar_date_counter import cdc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic [DayW-1:0]   load_day_i,
  input  logic [MonthW-1:0] load_month_i,
  input  logic [YearW-1:0]  load_year_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DayW-1:0]   day_o,
  output logic [MonthW-1:0] month_o,
  output logic [YearW-1:0]  year_o,
  output logic [WdayW-1:0]  weekday_o,
  output logic              weekend_o,
  output logic [DayW-1:0]   days_to_month_end_o,
  output logic [RemYW-1:0]  days_to_year_end_o,
  output logic              load_error_o
);

  // Stage valids and enables.
  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, eno;

  assign eno = !vo_q || !out_stall_i;
  assign en3 = !v3_q || eno;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (eno) vo_q <= v3_q;
    end
  end

  // Stage 1: input register.
  logic              act1_q;
  logic [DayW-1:0]   day1_q;
  logic [MonthW-1:0] mon1_q;
  logic [YearW-1:0]  yr1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      act1_q <= action_i;
      day1_q <= load_day_i;
      mon1_q <= load_month_i;
      yr1_q  <= load_year_i;
    end
  end

  // Stage 2: year / 100 as (year / 4) / 25 by reciprocal multiplication.
  logic [24:0]       prod;
  logic              act2_q;
  logic [DayW-1:0]   day2_q;
  logic [MonthW-1:0] mon2_q;
  logic [YearW-1:0]  yr2_q;
  logic [7:0]        q100_2_q;

  assign prod = 25'(yr1_q[13:2]) * 25'(DIV25_MULT);

  always_ff @(posedge clk_i) begin
    if (en2) begin
      act2_q   <= act1_q;
      day2_q   <= day1_q;
      mon2_q   <= mon1_q;
      yr2_q    <= yr1_q;
      q100_2_q <= prod[DIV25_SHIFT +: 8];
    end
  end

  // Stage 3: checked and prepared load.
  load_info_t        info;
  load_info_t        info3_q;
  logic              act3_q;
  logic [DayW-1:0]   day3_q;
  logic [MonthW-1:0] mon3_q;
  logic [YearW-1:0]  yr3_q;

  cdc_load_prep u_load_prep (
    .day_i   (day2_q),
    .month_i (mon2_q),
    .year_i  (yr2_q),
    .q100_i  (q100_2_q),
    .info_o  (info)
  );

  always_ff @(posedge clk_i) begin
    if (en3) begin
      act3_q  <= act2_q;
      day3_q  <= day2_q;
      mon3_q  <= mon2_q;
      yr3_q   <= yr2_q;
      info3_q <= info;
    end
  end

  // Date state; it changes only as a transaction enters the output register,
  // so it doubles as the output payload.
  date_state_t state_q, state_d, adv;
  logic        err_q, err_d;
  logic [DayW-1:0] rem_m_q, rem_m_d;

  cdc_date_step u_date_step (
    .cur_i (state_q),
    .nxt_o (adv)
  );

  always_comb begin
    state_d = state_q;
    err_d   = 1'b0;
    priority if (act3_q == ACT_ADVANCE) begin
      state_d = adv;
    end else if (info3_q.ok) begin
      state_d.day   = day3_q;
      state_d.month = mon3_q;
      state_d.year  = yr3_q;
      state_d.y4    = yr3_q[1:0];
      state_d.y100  = info3_q.y100;
      state_d.c4    = info3_q.c4;
      state_d.wd    = mod7(info3_q.wsum);
      state_d.rem_y = info3_q.rem_y;
    end else begin
      err_d = 1'b1;
    end
    rem_m_d = month_len(state_d.month, is_leap(state_d.y4, state_d.y100, state_d.c4)) -
              state_d.day;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DATE_RESET;
    end else if (eno && v3_q) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eno && v3_q) begin
      err_q   <= err_d;
      rem_m_q <= rem_m_d;
    end
  end

  assign out_valid_o         = vo_q;
  assign day_o               = state_q.day;
  assign month_o             = state_q.month;
  assign year_o              = state_q.year;
  assign weekday_o           = state_q.wd;
  assign weekend_o           = (state_q.wd == WDAY_FRI) || (state_q.wd == WDAY_SAT);
  assign days_to_month_end_o = rem_m_q;
  assign days_to_year_end_o  = state_q.rem_y;
  assign load_error_o        = err_q;

endmodule
